// ===== rtl/mft_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers of the memory freeze table.
// Used by mft_ctrl, mft_dp and memory_freeze_table; depends on nothing.
package mft_pkg;

   localparam int unsigned MaxEntriesDefault = 16;
   localparam logic [31:0] ByteMask          = 32'h0000_00FF;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_APPLY  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_WIDTH = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] value;
      logic [2:0]  nbytes;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       rd_en;
      logic       rd_next;
      logic       idx_inc;
      logic       wr_update;
      logic       wr_shift;
      logic       wr_append;
      logic       count_inc;
      logic       count_dec;
      logic       clear_count;
      logic       emit;
      status_type emit_status;
      logic       emit_write;
      logic       emit_last;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic    out_free;
      cmd_type cmd;
      logic    width_ok;
      logic    count_zero;
      logic    table_full;
      logic    match;
      logic    idx_last;
      logic    nxt_last;
   } dp_stat_type;

   function automatic logic [31:0] byte_mask(input logic [2:0] nbytes);
      logic [31:0] mask;
      case (nbytes)
         3'd1:    mask = ByteMask;
         3'd2:    mask = {16'h0000, ByteMask[7:0], ByteMask[7:0]};
         default: mask = '1;
      endcase
      return mask;
   endfunction

   function automatic logic width_legal(input logic [2:0] nbytes);
      return (nbytes == 3'd1) || (nbytes == 3'd2) || (nbytes == 3'd4);
   endfunction

endpackage

// ===== rtl/mft_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the memory freeze table: scans, shifts and result issue.
// Depends on mft_pkg; drives mft_dp through ctl_cmd_type.
module mft_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mft_pkg::dp_stat_type stat,
   output mft_pkg::ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_CHECK,
      S_SREAD,
      S_SWRITE,
      S_APPEND
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.cmd)
               mft_pkg::CMD_CLEAR: begin
                  if (stat.out_free) begin
                     cmd.clear_count = 1'b1;
                     cmd.emit        = 1'b1;
                     cmd.emit_status = mft_pkg::ST_OK;
                     cmd.emit_last   = 1'b1;
                     state_in        = S_IDLE;
                  end
               end
               mft_pkg::CMD_ADD: begin
                  if (!stat.width_ok) begin
                     if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = mft_pkg::ST_BAD_WIDTH;
                        cmd.emit_last   = 1'b1;
                        state_in        = S_IDLE;
                     end
                  end else if (stat.count_zero) begin
                     state_in = S_APPEND;
                  end else begin
                     state_in = S_READ;
                  end
               end
               mft_pkg::CMD_REMOVE: begin
                  if (stat.count_zero) begin
                     if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = mft_pkg::ST_NOT_FOUND;
                        cmd.emit_last   = 1'b1;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     state_in = S_READ;
                  end
               end
               default: begin
                  if (stat.count_zero) begin
                     if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = mft_pkg::ST_OK;
                        cmd.emit_last   = 1'b1;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     state_in = S_READ;
                  end
               end
            endcase
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            case (stat.cmd)
               mft_pkg::CMD_ADD: begin
                  if (stat.match) begin
                     if (stat.out_free) begin
                        cmd.wr_update   = 1'b1;
                        cmd.emit        = 1'b1;
                        cmd.emit_status = mft_pkg::ST_OK;
                        cmd.emit_last   = 1'b1;
                        state_in        = S_IDLE;
                     end
                  end else if (stat.idx_last) begin
                     if (!stat.table_full) begin
                        state_in = S_APPEND;
                     end else if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = mft_pkg::ST_FULL;
                        cmd.emit_last   = 1'b1;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     cmd.idx_inc = 1'b1;
                     state_in    = S_READ;
                  end
               end
               mft_pkg::CMD_REMOVE: begin
                  if (stat.match) begin
                     if (!stat.idx_last) begin
                        state_in = S_SREAD;
                     end else if (stat.out_free) begin
                        cmd.count_dec   = 1'b1;
                        cmd.emit        = 1'b1;
                        cmd.emit_status = mft_pkg::ST_OK;
                        cmd.emit_last   = 1'b1;
                        state_in        = S_IDLE;
                     end
                  end else if (stat.idx_last) begin
                     if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = mft_pkg::ST_NOT_FOUND;
                        cmd.emit_last   = 1'b1;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     cmd.idx_inc = 1'b1;
                     state_in    = S_READ;
                  end
               end
               mft_pkg::CMD_APPLY: begin
                  if (stat.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = mft_pkg::ST_OK;
                     cmd.emit_write  = 1'b1;
                     cmd.emit_last   = stat.idx_last;
                     if (stat.idx_last) begin
                        state_in = S_IDLE;
                     end else begin
                        cmd.idx_inc = 1'b1;
                        state_in    = S_READ;
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SREAD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
            state_in    = S_SWRITE;
         end
         S_SWRITE: begin
            if (!stat.nxt_last) begin
               cmd.wr_shift = 1'b1;
               cmd.idx_inc  = 1'b1;
               state_in     = S_SREAD;
            end else if (stat.out_free) begin
               cmd.wr_shift    = 1'b1;
               cmd.count_dec   = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_status = mft_pkg::ST_OK;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_APPEND: begin
            if (stat.out_free) begin
               cmd.wr_append   = 1'b1;
               cmd.count_inc   = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_status = mft_pkg::ST_OK;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted beat did not advance to decode");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWRITE) |-> !stat.idx_last)
      else $error("shift step at the final entry");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPEND) |-> !stat.table_full)
      else $error("append into a full table");

endmodule

// ===== rtl/mft_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the memory freeze table: request latch, entry memory, count, index, result register.
// Depends on mft_pkg; steered by mft_ctrl.
module mft_dp #(
   parameter  int unsigned MaxEntries = mft_pkg::MaxEntriesDefault,
   localparam int unsigned CntW       = $clog2(MaxEntries + 1),
   localparam int unsigned IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_cmd,
   input  logic [31:0]          req_address,
   input  logic [31:0]          req_value,
   input  logic [2:0]           req_byte_count,
   input  mft_pkg::ctl_cmd_type cmd,
   output mft_pkg::dp_stat_type stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic                 rsp_write_valid,
   output logic [31:0]          rsp_write_address,
   output logic [31:0]          rsp_write_data,
   output logic [2:0]           rsp_write_bytes,
   output logic                 rsp_last
);

   mft_pkg::cmd_type    req_cmd_ff;
   logic [31:0]         req_address_ff;
   logic [31:0]         req_value_ff;
   logic [2:0]          req_bytes_ff;
   logic [IdxW-1:0]     idx_ff;
   logic [CntW-1:0]     count_ff;
   mft_pkg::entry_type  entry_mem_ff [MaxEntries];
   mft_pkg::entry_type  rd_data_ff;
   logic [IdxW-1:0]     rd_addr;
   logic                wr_en;
   logic [IdxW-1:0]     wr_addr;
   mft_pkg::entry_type  wr_data;
   logic                rsp_valid_ff;
   mft_pkg::status_type rsp_status_ff;
   logic                rsp_write_valid_ff;
   logic [31:0]         rsp_write_address_ff;
   logic [31:0]         rsp_write_data_ff;
   logic [2:0]          rsp_write_bytes_ff;
   logic                rsp_last_ff;

   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.cmd        = req_cmd_ff;
   assign stat.width_ok   = mft_pkg::width_legal(req_bytes_ff);
   assign stat.count_zero = (count_ff == '0);
   assign stat.table_full = (count_ff == CntW'(MaxEntries));
   assign stat.match      = (rd_data_ff.address == req_address_ff);
   assign stat.idx_last   = ((CntW + 1)'(idx_ff) + (CntW + 1)'(1)) == (CntW + 1)'(count_ff);
   assign stat.nxt_last   = ((CntW + 1)'(idx_ff) + (CntW + 1)'(2)) == (CntW + 1)'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_cmd_ff     <= mft_pkg::cmd_type'(req_cmd);
         req_address_ff <= req_address;
         req_value_ff   <= req_value;
         req_bytes_ff   <= req_byte_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         if (cmd.clear_count) begin
            count_ff <= '0;
         end else if (cmd.count_inc) begin
            count_ff <= count_ff + CntW'(1);
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - CntW'(1);
         end
         if (cmd.capture) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + IdxW'(1);
         end
      end
   end

   // entry memory: one write port, one registered read port
   assign rd_addr = cmd.rd_next ? (idx_ff + IdxW'(1)) : idx_ff;
   assign wr_en   = cmd.wr_update || cmd.wr_shift || cmd.wr_append;
   assign wr_addr = cmd.wr_append ? count_ff[IdxW-1:0] : idx_ff;
   assign wr_data = cmd.wr_shift ? rd_data_ff
                                 : mft_pkg::entry_type'{address: req_address_ff,
                                                        value: req_value_ff,
                                                        nbytes: req_bytes_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff      <= cmd.emit_status;
         rsp_write_valid_ff <= cmd.emit_write;
         rsp_last_ff        <= cmd.emit_last;
         if (cmd.emit_write) begin
            rsp_write_address_ff <= rd_data_ff.address;
            rsp_write_data_ff    <= rd_data_ff.value & mft_pkg::byte_mask(rd_data_ff.nbytes);
            rsp_write_bytes_ff   <= rd_data_ff.nbytes;
         end else begin
            rsp_write_address_ff <= '0;
            rsp_write_data_ff    <= '0;
            rsp_write_bytes_ff   <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_write_valid   = rsp_write_valid_ff;
   assign rsp_write_address = rsp_write_address_ff;
   assign rsp_write_data    = rsp_write_data_ff;
   assign rsp_write_bytes   = rsp_write_bytes_ff;
   assign rsp_last          = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxEntries))
      else $error("entry count beyond table depth");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("result issued over a held beat");

   a_plain_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_write_valid_ff) |->
      (rsp_write_address_ff == '0 && rsp_write_data_ff == '0 && rsp_write_bytes_ff == '0))
      else $error("write fields set on a status-only beat");

   a_write_width: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_write_valid_ff) |->
      ((rsp_write_bytes_ff == 3'd1 || rsp_write_bytes_ff == 3'd2 ||
        rsp_write_bytes_ff == 3'd4) &&
       ((rsp_write_data_ff & ~mft_pkg::byte_mask(rsp_write_bytes_ff)) == '0)))
      else $error("write beat with illegal width or unmasked data");

endmodule

// ===== rtl/memory_freeze_table.sv =====
`timescale 1ns / 1ps
// Top level of the memory freeze table: bounded ordered table of memory patches.
// Depends on mft_pkg, mft_ctrl and mft_dp.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  cmd, address, value, byte_count
//   rsp_     out        rsp_valid/rsp_ready  status, write_valid, write_address,
//                                            write_data, write_bytes, last
//
// Clear and bad-width adds finish in decode; add, remove and apply then read and check
// each entry visited in turn, an add that appends adds an append step, and a remove
// moves each later entry up one place, by a read and a write step, to close the gap.
// The separate read and check steps come from the registered read of the entry memory.
// Reset is synchronous and empties the table; entry contents are not cleared.
// A held result beat stalls the scan only at the step that issues the next result.
module memory_freeze_table #(
   parameter int unsigned MaxEntries = mft_pkg::MaxEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_address,
   input  logic [31:0] req_value,
   input  logic [2:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_write_valid,
   output logic [31:0] rsp_write_address,
   output logic [31:0] rsp_write_data,
   output logic [2:0]  rsp_write_bytes,
   output logic        rsp_last
);

   mft_pkg::ctl_cmd_type ctl_cmd;
   mft_pkg::dp_stat_type dp_stat;

   mft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (ctl_cmd)
   );

   mft_dp #(
      .MaxEntries (MaxEntries)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_cmd),
      .req_address       (req_address),
      .req_value         (req_value),
      .req_byte_count    (req_byte_count),
      .cmd               (ctl_cmd),
      .stat              (dp_stat),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_write_bytes   (rsp_write_bytes),
      .rsp_last          (rsp_last)
   );

endmodule
